FILE: rtl/vshi_pkg.sv
// Shared types and constants for the voxel slice hollow interior unit.
// No dependencies; every other file except vshi_ram imports this package.
`default_nettype none
package vshi_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int MAX_DEPTH   = 64;
   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS    = $clog2(MAX_DEPTH);
   localparam int ADDR_BITS   = X_BITS + ROW_BITS;
   localparam int BANK_DEPTH  = MAX_WIDTH * MAX_DEPTH;
   localparam int ENTRY_BITS  = 33;
   localparam int NUM_BANKS   = 3;
   localparam int CMD_DEPTH   = 2;
   localparam int RSP_DEPTH   = 4;
   localparam int MAX_HEIGHT  = 4096;

   localparam logic [6:0]  WIDTH_CAP  = 7'(MAX_WIDTH);
   localparam logic [6:0]  DEPTH_CAP  = 7'(MAX_DEPTH);
   localparam logic [12:0] HEIGHT_CAP = 13'(MAX_HEIGHT);
   localparam logic [31:0] WHITE      = 32'hFFFF_FFFF;

   localparam logic [1:0] BANK_0 = 2'd0;
   localparam logic [1:0] BANK_1 = 2'd1;
   localparam logic [1:0] BANK_2 = 2'd2;

   typedef enum logic [2:0] {
      CSR_WIDTH     = 3'd0,
      CSR_DEPTH     = 3'd1,
      CSR_HEIGHT    = 3'd2,
      CSR_TOP_LAYER = 3'd3,
      CSR_HOLLOW    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [6:0]  width;
      logic [6:0]  depth;
      logic [12:0] height;
      logic [15:0] top_layer;
      logic        hollow;
   } csr_type;

   typedef struct packed {
      logic [X_BITS-1:0]   x;
      logic [ROW_BITS-1:0] row;
      logic [1:0]          cur;
      logic [1:0]          prev;
      logic [1:0]          older;
      logic                solid;
      logic [31:0]         color;
      logic                has_result;
      logic                older_ok;
      logic                east_ok;
      logic                west_ok;
      logic                north_ok;
      logic                south_ok;
      logic                slice_end;
      logic [15:0]         layer;
   } cmd_type;

   typedef struct packed {
      logic [31:0] pixel_color;
      logic [15:0] layer;
      logic [5:0]  column;
      logic [5:0]  row;
      logic        last_of_slice;
      logic        slice_empty;
   } rsp_type;

   function automatic logic [ENTRY_BITS-1:0] pick_bank(
      input logic [1:0]            sel,
      input logic [ENTRY_BITS-1:0] d0,
      input logic [ENTRY_BITS-1:0] d1,
      input logic [ENTRY_BITS-1:0] d2
   );
      logic [ENTRY_BITS-1:0] r;
      case (sel)
         BANK_0:  r = d0;
         BANK_1:  r = d1;
         default: r = d2;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/vshi_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module vshi_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     write_en,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr_a,
   output logic      [WIDTH-1:0]         read_data_a,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr_b,
   output logic      [WIDTH-1:0]         read_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[write_addr] <= write_data;
      end
      rd_a_ff <= mem_ff[read_addr_a];
      rd_b_ff <= mem_ff[read_addr_b];
   end

   assign read_data_a = rd_a_ff;
   assign read_data_b = rd_b_ff;
endmodule
`default_nettype wire

FILE: rtl/vshi_front.sv
// Front end: accepts voxels, tracks position, slice and bank rotation,
// and builds one command per voxel. Depends on vshi_pkg.
`default_nettype none
module vshi_front import vshi_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire csr_type     csr,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic        req_solid,
   input  wire logic [31:0] req_voxel_color,
   input  wire logic        q_full,
   output logic             q_push,
   output cmd_type          q_cmd
);
   logic [X_BITS-1:0]   pos_x_ff, pos_x_in;
   logic [ROW_BITS-1:0] pos_row_ff, pos_row_in;
   logic [12:0]         slice_count_ff, slice_count_in;
   logic [1:0]          bank_ff, bank_in;

   logic [6:0]  w, d, x7, r7;
   logic [12:0] h;
   logic        row_end, slice_end, padding;

   always_comb begin
      w = (csr.width == 7'd0) ? 7'd1 : (csr.width > WIDTH_CAP) ? WIDTH_CAP : csr.width;
      d = (csr.depth == 7'd0) ? 7'd1 : (csr.depth > DEPTH_CAP) ? DEPTH_CAP : csr.depth;
      h = (csr.height == 13'd0) ? 13'd1 :
          (csr.height > HEIGHT_CAP) ? HEIGHT_CAP : csr.height;
      x7 = 7'(pos_x_ff);
      r7 = 7'(pos_row_ff);
      row_end   = (x7 + 7'd1) >= w;
      slice_end = row_end && ((r7 + 7'd1) >= d);
      padding   = slice_count_ff >= h;

      q_cmd.x          = pos_x_ff;
      q_cmd.row        = pos_row_ff;
      q_cmd.cur        = bank_ff;
      q_cmd.prev       = (bank_ff == BANK_0) ? BANK_2 : bank_ff - 2'd1;
      q_cmd.older      = (bank_ff == BANK_2) ? BANK_0 : bank_ff + 2'd1;
      q_cmd.solid      = req_solid && !padding;
      q_cmd.color      = req_voxel_color;
      q_cmd.has_result = slice_count_ff != 13'd0;
      q_cmd.older_ok   = slice_count_ff >= 13'd2;
      q_cmd.east_ok    = (x7 + 7'd1) < w;
      q_cmd.west_ok    = (pos_x_ff != '0) && ((x7 - 7'd1) < w);
      q_cmd.north_ok   = (pos_row_ff != '0) && ((r7 - 7'd1) < d);
      q_cmd.south_ok   = (r7 + 7'd1) < d;
      q_cmd.slice_end  = slice_end;
      q_cmd.layer      = csr.top_layer + 16'd1 - 16'(slice_count_ff);

      req_full = q_full;
      q_push   = req_push && !q_full;

      pos_x_in       = pos_x_ff;
      pos_row_in     = pos_row_ff;
      slice_count_in = slice_count_ff;
      bank_in        = bank_ff;
      if (q_push) begin
         if (row_end) begin
            pos_x_in = '0;
            if (slice_end) begin
               pos_row_in     = '0;
               bank_in        = q_cmd.older;
               slice_count_in = padding ? 13'd0 : slice_count_ff + 13'd1;
            end else begin
               pos_row_in = pos_row_ff + 1'b1;
            end
         end else begin
            pos_x_in = pos_x_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff       <= '0;
         pos_row_ff     <= '0;
         slice_count_ff <= '0;
         bank_ff        <= BANK_0;
      end else begin
         pos_x_ff       <= pos_x_in;
         pos_row_ff     <= pos_row_in;
         slice_count_ff <= slice_count_in;
         bank_ff        <= bank_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/vshi_cmd_queue.sv
// Two-entry command queue between front and back end.
// Depends on vshi_pkg.
`default_nettype none
module vshi_cmd_queue import vshi_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   output logic         full,
   input  wire logic    pop,
   output logic         valid,
   output cmd_type      head
);
   localparam int PTR_BITS = $clog2(CMD_DEPTH);

   cmd_type             entry_ff [CMD_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PTR_BITS:0]   count_ff, count_in;

   assign full  = count_ff == (PTR_BITS + 1)'(CMD_DEPTH);
   assign valid = count_ff != '0;
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/vshi_back.sv
// Back end: slice store banks, neighbor reads, hollow test
// and result queue. Depends on vshi_pkg and vshi_ram.
`default_nettype none
module vshi_back import vshi_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    hollow,
   input  wire logic    q_valid,
   input  wire cmd_type q_head,
   output logic         q_pop,
   output logic         rsp_empty,
   input  wire logic    rsp_pop,
   output rsp_type      rsp
);
   localparam int RPTR_BITS = $clog2(RSP_DEPTH);

   logic                  phase_ff;
   cmd_type               exec_ff, calc_ff;
   logic                  calc_valid_ff;
   logic [ENTRY_BITS-1:0] own_ff, east_ff, older_ff, west_ff;
   logic                  content_ff, content_in;

   rsp_type               rsp_ff [RSP_DEPTH];
   logic [RPTR_BITS-1:0]  rwr_ff, rrd_ff;
   logic [RPTR_BITS:0]    rcount_ff, rcount_in;

   logic                  issue;
   logic [ADDR_BITS-1:0]  addr_a, addr_b, waddr;
   logic [ENTRY_BITS-1:0] rda [NUM_BANKS];
   logic [ENTRY_BITS-1:0] rdb [NUM_BANKS];
   logic [NUM_BANKS-1:0]  we;

   logic [ENTRY_BITS-1:0] north, south;
   logic [31:0]           color;
   logic                  solid, buried, keep, content, rsp_push, rsp_take;
   rsp_type               result;

   assign issue = !phase_ff && q_valid &&
                  (({1'b0, rcount_ff} + (RPTR_BITS + 2)'(calc_valid_ff))
                   < (RPTR_BITS + 2)'(RSP_DEPTH));
   assign q_pop = issue;
   assign waddr = {q_head.row, q_head.x};

   always_comb begin
      if (phase_ff) begin
         addr_a = {exec_ff.row - 1'b1, exec_ff.x};
         addr_b = {exec_ff.row + 1'b1, exec_ff.x};
      end else begin
         addr_a = {q_head.row, q_head.x};
         addr_b = {q_head.row, q_head.x + 1'b1};
      end
   end

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      assign we[b] = issue && (q_head.cur == 2'(b));
      vshi_ram #(.WIDTH(ENTRY_BITS), .DEPTH(BANK_DEPTH)) u_ram (
         .clock       (clock),
         .write_en    (we[b]),
         .write_addr  (waddr),
         .write_data  ({q_head.solid, q_head.color}),
         .read_addr_a (addr_a),
         .read_data_a (rda[b]),
         .read_addr_b (addr_b),
         .read_data_b (rdb[b])
      );
   end

   function automatic logic nb_keep(input logic ok, input logic [ENTRY_BITS-1:0] nb);
      return ok && nb[32] && (nb[31:24] != 8'd0) && (nb[31:0] != WHITE);
   endfunction

   always_comb begin
      north = pick_bank(calc_ff.prev, rda[0], rda[1], rda[2]);
      south = pick_bank(calc_ff.prev, rdb[0], rdb[1], rdb[2]);
      solid = own_ff[32];
      color = solid ? own_ff[31:0] : 32'd0;
      buried = calc_ff.solid && calc_ff.older_ok && older_ff[32] &&
               calc_ff.east_ok && east_ff[32] && calc_ff.west_ok && west_ff[32] &&
               calc_ff.north_ok && north[32] && calc_ff.south_ok && south[32];
      keep = nb_keep(calc_ff.east_ok, east_ff) || nb_keep(calc_ff.west_ok, west_ff) ||
             nb_keep(calc_ff.north_ok, north) || nb_keep(calc_ff.south_ok, south);
      if (hollow && solid && (color == WHITE) && buried && !keep) begin
         color = 32'd0;
      end
      content = hollow ? (color[31:24] != 8'd0) : solid;

      rsp_push   = calc_valid_ff && calc_ff.has_result;
      content_in = content_ff;
      if (calc_valid_ff) begin
         content_in = calc_ff.slice_end ? 1'b0 : (content_ff || (calc_ff.has_result && content));
      end

      result.pixel_color   = color;
      result.layer         = calc_ff.layer;
      result.column        = calc_ff.x;
      result.row           = calc_ff.row;
      result.last_of_slice = calc_ff.slice_end;
      result.slice_empty   = calc_ff.slice_end && !(content_ff || content);

      rsp_take = rsp_pop && !rsp_empty;
      rcount_in = rcount_ff;
      if (rsp_push && !rsp_take) begin
         rcount_in = rcount_ff + 1'b1;
      end else if (rsp_take && !rsp_push) begin
         rcount_in = rcount_ff - 1'b1;
      end
   end

   assign rsp_empty = rcount_ff == '0;
   assign rsp       = rsp_ff[rrd_ff];

   always_ff @(posedge clock) begin
      if (issue) begin
         exec_ff <= q_head;
      end
      if (phase_ff) begin
         own_ff   <= pick_bank(exec_ff.prev, rda[0], rda[1], rda[2]);
         east_ff  <= pick_bank(exec_ff.prev, rdb[0], rdb[1], rdb[2]);
         older_ff <= pick_bank(exec_ff.older, rda[0], rda[1], rda[2]);
         calc_ff  <= exec_ff;
      end
      if (calc_valid_ff) begin
         west_ff <= own_ff;
      end
      if (rsp_push) begin
         rsp_ff[rwr_ff] <= result;
      end
      if (reset) begin
         phase_ff      <= 1'b0;
         calc_valid_ff <= 1'b0;
         content_ff    <= 1'b0;
         rwr_ff        <= '0;
         rrd_ff        <= '0;
         rcount_ff     <= '0;
      end else begin
         phase_ff      <= issue;
         calc_valid_ff <= phase_ff;
         content_ff    <= content_in;
         if (rsp_push) begin
            rwr_ff <= rwr_ff + 1'b1;
         end
         if (rsp_take) begin
            rrd_ff <= rrd_ff + 1'b1;
         end
         rcount_ff <= rcount_in;
      end
   end
endmodule
`default_nettype wire

FILE: rtl/voxel_slice_hollow_interior_unit.sv
// Top level of the voxel slice hollow interior unit: configuration registers,
// front end, command queue and back end. Depends on vshi_pkg and submodules.
//
// Usage: voxels enter on the req_ queue port (push/full), one per transfer,
// slice by slice from the top layer down, rows from upper z, x ascending.
// Pixels of slice s leave on the rsp_ queue port (empty/pop) while slice s+1
// arrives; after the last real slice send one padding slice to flush.
// No pixel is produced during the first slice of a volume.
// The back end takes a new command only once the reads of the current voxel
// (five store reads on the dual-port slice store banks) are issued, and only
// while the result queue has room; the calc stage then feeds the result queue.
// A 2-entry command queue and a 4-entry result queue decouple the sides;
// when pop stays low the result queue fills, then the command queue, then
// full rises. Reset (synchronous) clears position, slice count, bank
// rotation and queues and loads register defaults; store contents persist.
// Write csr_ registers only while idle.
`default_nettype none
module voxel_slice_hollow_interior_unit import vshi_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_solid,
   input  wire logic [31:0] req_voxel_color,
   output logic             empty,
   input  wire logic        pop,
   output logic      [31:0] rsp_pixel_color,
   output logic      [15:0] rsp_layer,
   output logic      [5:0]  rsp_column,
   output logic      [5:0]  rsp_row,
   output logic             rsp_last_of_slice,
   output logic             rsp_slice_empty
);
   csr_type csr_ff;
   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_cmd, q_head;
   rsp_type rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.width     <= WIDTH_CAP;
         csr_ff.depth     <= DEPTH_CAP;
         csr_ff.height    <= 13'd1;
         csr_ff.top_layer <= 16'd0;
         csr_ff.hollow    <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WIDTH:     csr_ff.width     <= csr_wdata[6:0];
            CSR_DEPTH:     csr_ff.depth     <= csr_wdata[6:0];
            CSR_HEIGHT:    csr_ff.height    <= csr_wdata[12:0];
            CSR_TOP_LAYER: csr_ff.top_layer <= csr_wdata;
            CSR_HOLLOW:    csr_ff.hollow    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   vshi_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr             (csr_ff),
      .req_push        (push),
      .req_full        (full),
      .req_solid       (req_solid),
      .req_voxel_color (req_voxel_color),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (q_cmd)
   );

   vshi_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   vshi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .hollow    (csr_ff.hollow),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (empty),
      .rsp_pop   (pop),
      .rsp       (rsp)
   );

   assign rsp_pixel_color   = rsp.pixel_color;
   assign rsp_layer         = rsp.layer;
   assign rsp_column        = rsp.column;
   assign rsp_row           = rsp.row;
   assign rsp_last_of_slice = rsp.last_of_slice;
   assign rsp_slice_empty   = rsp.slice_empty;
endmodule
`default_nettype wire

FILE: tb/sv/voxel_slice_hollow_interior_unit_test.sv
// Self-checking testbench for voxel_slice_hollow_interior_unit: drives voxel volumes,
// predicts every pixel with its own slice store model and checks each transfer.
// Depends on vshi_pkg and the RTL of the unit.
`default_nettype none
module voxel_slice_hollow_interior_unit_test;
   import vshi_pkg::*;

   typedef struct {
      bit        solid;
      bit [31:0] color;
   } voxel_type;

   logic        clock;
   logic        reset;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        push;
   logic        full;
   logic        req_solid;
   logic [31:0] req_voxel_color;
   logic        empty;
   logic        pop;
   logic [31:0] rsp_pixel_color;
   logic [15:0] rsp_layer;
   logic [5:0]  rsp_column;
   logic [5:0]  rsp_row;
   logic        rsp_last_of_slice;
   logic        rsp_slice_empty;

   voxel_slice_hollow_interior_unit u_top (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .push(push), .full(full), .req_solid(req_solid), .req_voxel_color(req_voxel_color),
      .empty(empty), .pop(pop),
      .rsp_pixel_color(rsp_pixel_color), .rsp_layer(rsp_layer), .rsp_column(rsp_column),
      .rsp_row(rsp_row), .rsp_last_of_slice(rsp_last_of_slice),
      .rsp_slice_empty(rsp_slice_empty)
   );

   voxel_type pending_voxels[$];
   rsp_type   expected_pixels[$];
   int        mismatches = 0;
   int        push_gap = 0;
   int        pop_gap = 0;
   int        pop_hold = 0;
   bit        hold_request = 0;
   int        voxels_sent = 0;

   // predictor state
   bit [32:0]   slice_mem[3][BANK_DEPTH];
   int          at_x, at_row, slices_seen, bank_turn;
   bit          has_content;
   bit [6:0]    cfg_width, cfg_depth;
   bit [12:0]   cfg_height;
   bit [15:0]   cfg_top;
   bit          cfg_hollow;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic int clamp_extent(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void reset_pixel_model();
      at_x = 0; at_row = 0; slices_seen = 0; bank_turn = 0; has_content = 0;
      cfg_width = 7'd64; cfg_depth = 7'd64; cfg_height = 13'd1;
      cfg_top = 16'd0; cfg_hollow = 1'b0;
   endfunction

   function automatic void predict_pixel(bit solid_in, bit [31:0] color_in);
      int        w, d, h, cur, prv, older, nx, nr;
      bit        padding, in_solid, row_end, slice_end, buried, keep, content;
      bit [32:0] own, nb;
      bit [31:0] color;
      rsp_type   px;
      w = clamp_extent(cfg_width, MAX_WIDTH);
      d = clamp_extent(cfg_depth, MAX_DEPTH);
      h = clamp_extent(cfg_height, MAX_HEIGHT);
      cur = bank_turn;
      prv = (cur + 2) % 3;
      older = (cur + 1) % 3;
      padding = slices_seen >= h;
      in_solid = !padding && solid_in;
      row_end = at_x + 1 >= w;
      slice_end = row_end && at_row + 1 >= d;
      if (slices_seen >= 1) begin
         own = slice_mem[prv][at_row * MAX_WIDTH + at_x];
         color = own[32] ? own[31:0] : 32'd0;
         if (cfg_hollow && own[32] && color == WHITE) begin
            buried = in_solid;
            keep = 0;
            if (slices_seen < 2 || !slice_mem[older][at_row * MAX_WIDTH + at_x][32])
               buried = 0;
            for (int k = 0; k < 4; k++) begin
               nx = at_x; nr = at_row;
               case (k)
                  0: nx = at_x + 1;
                  1: nx = at_x - 1;
                  2: nr = at_row - 1;
                  default: nr = at_row + 1;
               endcase
               if (nx < 0 || nx >= w || nr < 0 || nr >= d) begin
                  buried = 0;
               end else begin
                  nb = slice_mem[prv][nr * MAX_WIDTH + nx];
                  if (!nb[32]) buried = 0;
                  else if (nb[31:24] != 8'd0 && nb[31:0] != WHITE) keep = 1;
               end
            end
            if (buried && !keep) color = 32'd0;
         end
         content = cfg_hollow ? (color[31:24] != 8'd0) : own[32];
         if (content) has_content = 1;
         px.pixel_color = color;
         px.layer = cfg_top - 16'(slices_seen - 1);
         px.column = 6'(at_x);
         px.row = 6'(at_row);
         px.last_of_slice = slice_end;
         px.slice_empty = slice_end && !has_content;
         expected_pixels.insert(expected_pixels.size(), px);
      end
      slice_mem[cur][at_row * MAX_WIDTH + at_x] = in_solid ? {1'b1, color_in} : 33'd0;
      if (row_end) begin
         at_x = 0;
         if (slice_end) begin
            at_row = 0;
            bank_turn = (cur + 1) % 3;
            has_content = 0;
            slices_seen = padding ? 0 : slices_seen + 1;
         end else begin
            at_row = at_row + 1;
         end
      end else begin
         at_x = at_x + 1;
      end
   endfunction

   // monitor: input transfers, register writes, result transfers
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         reset_pixel_model();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_WIDTH:     cfg_width = csr_wdata[6:0];
               CSR_DEPTH:     cfg_depth = csr_wdata[6:0];
               CSR_HEIGHT:    cfg_height = csr_wdata[12:0];
               CSR_TOP_LAYER: cfg_top = csr_wdata;
               CSR_HOLLOW:    cfg_hollow = csr_wdata[0];
               default: ;
            endcase
         end
         if (push && !full) begin
            predict_pixel(req_solid, req_voxel_color);
            void'(pending_voxels.pop_front());
            push_gap = pick_gap();
         end
         if (pop && !empty) begin
            if (expected_pixels.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pixel transfer: col %0d row %0d color %h",
                           rsp_column, rsp_row, rsp_pixel_color);
            end else begin
               want = expected_pixels.pop_front();
               if (want.pixel_color !== rsp_pixel_color || want.layer !== rsp_layer ||
                   want.column !== rsp_column || want.row !== rsp_row ||
                   want.last_of_slice !== rsp_last_of_slice ||
                   want.slice_empty !== rsp_slice_empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("pixel mismatch: expected %h %h %0d %0d %b %b got %h %h %0d %0d %b %b",
                              want.pixel_color, want.layer, want.column, want.row,
                              want.last_of_slice, want.slice_empty,
                              rsp_pixel_color, rsp_layer, rsp_column, rsp_row,
                              rsp_last_of_slice, rsp_slice_empty);
               end
            end
         end
      end
   end

   // voxel driver
   always @(negedge clock) begin
      if (push_gap > 0) begin
         push_gap--;
         push <= 1'b0;
      end else if (pending_voxels.size() > 0) begin
         push <= 1'b1;
         req_solid <= pending_voxels[0].solid;
         req_voxel_color <= pending_voxels[0].color;
      end else begin
         push <= 1'b0;
      end
   end

   // pixel receiver
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 0;
         pop_hold = 400;
      end
      if (pop_hold > 0) begin
         pop_hold--;
         pop <= 1'b0;
      end else if (pop_gap > 0) begin
         pop_gap--;
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
         pop_gap = pick_gap();
      end
   end

   task automatic write_reg(csr_index_type idx, bit [15:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   task automatic wait_idle();
      wait (pending_voxels.size() == 0 && expected_pixels.size() == 0);
      repeat (12) @(posedge clock);
   endtask

   function automatic voxel_type random_voxel(bit noise);
      voxel_type v;
      int        p;
      v.color = $urandom;
      if (noise) begin
         v.solid = $urandom_range(0, 1);
         return v;
      end
      v.solid = $urandom_range(0, 99) < 80;
      p = $urandom_range(0, 99);
      if (p < 60) v.color = WHITE;
      else if (p < 80) v.color[31:24] = 8'd0;
      return v;
   endfunction

   // all_white: every voxel opaque white; otherwise random content
   task automatic run_volume(bit [15:0] w, bit [15:0] d, bit [15:0] h, bit [15:0] top,
                             bit hollow, bit all_white);
      int        n;
      bit        noise;
      voxel_type v;
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_DEPTH, d);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_TOP_LAYER, top);
      write_reg(CSR_HOLLOW, {15'd0, hollow});
      @(negedge clock);
      csr_write <= 1'b0;
      n = clamp_extent(w[6:0], MAX_WIDTH) * clamp_extent(d[6:0], MAX_DEPTH)
          * (clamp_extent(h[12:0], MAX_HEIGHT) + 1);
      noise = $urandom_range(0, 99) < 15;
      for (int i = 0; i < n; i++) begin
         if (all_white) begin
            v.solid = 1;
            v.color = WHITE;
         end else begin
            v = random_voxel(noise);
         end
         pending_voxels.insert(pending_voxels.size(), v);
      end
      voxels_sent += n;
      wait_idle();
   endtask

   initial begin
      bit [15:0] w, d, h;
      int        phase;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;
      push = 1'b0;
      pop = 1'b0;
      req_solid = 1'b0;
      req_voxel_color = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_volume(3, 3, 3, 16'h8001, 1, 1);
      run_volume(0, 0, 0, 16'h7FFF, 0, 0);
      run_volume(127, 1, 1, 16'h8000, 1, 0);
      run_volume(1, 64, 1, 16'h0000, 0, 0);

      phase = 0;
      while (voxels_sent < 800) begin
         w = $urandom_range(1, 6);
         d = $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         case ($urandom_range(0, 9))
            0: w = 0;
            1: d = 0;
            2: h = 0;
            default: ;
         endcase
         if (phase == 3) hold_request = 1;
         run_volume(w, d, h, 16'($urandom), $urandom_range(0, 1), 0);
         phase++;
      end
      run_volume(1, 1, 16'h0010, 16'h0005, 1, 0);

      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
